### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/rio_pkg.sv
// ----------------------------------------------------------------------------
// rio_pkg
// Shared types, widths and codes of the RAM, I/O port and timer device.
// ----------------------------------------------------------------------------
`default_nettype none

package rio_pkg;

    localparam int MODE_W  = 3;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int PC_W    = 6;
    localparam int CNT_W   = 14;
    localparam int CAM_W   = 16;
    localparam int STAT_W  = 7;
    localparam int PORTS   = 3;

    localparam int RIO_RAM_DEPTH = 256;

    // event codes
    typedef enum logic [MODE_W-1:0] {
        MODE_IO_WR  = 3'd0,
        MODE_IO_RD  = 3'd1,
        MODE_RAM_WR = 3'd2,
        MODE_RAM_RD = 3'd3,
        MODE_PIN_A  = 3'd4,
        MODE_PIN_B  = 3'd5,
        MODE_PIN_C  = 3'd6,
        MODE_CLOCK  = 3'd7
    } t_mode;

    // register indexes
    localparam logic [2:0] REG_CMD = 3'd0;
    localparam logic [2:0] REG_PA  = 3'd1;
    localparam logic [2:0] REG_PB  = 3'd2;
    localparam logic [2:0] REG_PC  = 3'd3;
    localparam logic [2:0] REG_TLO = 3'd4;
    localparam logic [2:0] REG_THI = 3'd5;

    // timer command field of the command register
    localparam logic [1:0] TCMD_NOP     = 2'd0;
    localparam logic [1:0] TCMD_STOP    = 2'd1;
    localparam logic [1:0] TCMD_STOP_TC = 2'd2;
    localparam logic [1:0] TCMD_START   = 2'd3;

    // port C modes of the command register
    localparam logic [1:0] PC_MODE3 = 2'd1;
    localparam logic [1:0] PC_MODE4 = 2'd2;

    // status bit positions
    localparam int ST_INTR_A = 0;
    localparam int ST_BF_A   = 1;
    localparam int ST_INTE_A = 2;
    localparam int ST_INTR_B = 3;
    localparam int ST_BF_B   = 4;
    localparam int ST_INTE_B = 5;
    localparam int ST_TIMER  = 6;

    localparam logic [CNT_W-1:0] CNT_RESET = 14'h3fff;
    localparam logic [CAM_W-1:0] CAM_RESET = 16'h3fff;
    localparam logic [CNT_W-1:0] CNT_MIN   = 14'd2;
    localparam logic [DATA_W-1:0] RD_UNUSED = 8'hff;

    typedef struct packed {
        t_mode             mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] pin_mask;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] port_a_drive;
        logic [DATA_W-1:0] port_b_drive;
        logic [PC_W-1:0]   port_c_drive;
        logic [PORTS-1:0]  port_drive_enables;
        logic              timer_out;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/rio_in_if.sv
// ----------------------------------------------------------------------------
// rio_in_if
// Event channel: valid/ready handshake with one event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rio_in_if;
    logic                       valid;
    logic                       ready;
    logic [rio_pkg::MODE_W-1:0] mode;
    logic [rio_pkg::ADDR_W-1:0] addr;
    logic [rio_pkg::DATA_W-1:0] data;
    logic [rio_pkg::DATA_W-1:0] pin_mask;

    modport source (output valid, output mode, output addr, output data, output pin_mask,
                    input ready);
    modport sink   (input valid, input mode, input addr, input data, input pin_mask,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/rio_out_if.sv
// ----------------------------------------------------------------------------
// rio_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rio_out_if;
    logic                        valid;
    logic                        ready;
    logic [rio_pkg::DATA_W-1:0]  read_data;
    logic [rio_pkg::DATA_W-1:0]  port_a_drive;
    logic [rio_pkg::DATA_W-1:0]  port_b_drive;
    logic [rio_pkg::PC_W-1:0]    port_c_drive;
    logic [rio_pkg::PORTS-1:0]   port_drive_enables;
    logic                        timer_out;

    modport source (output valid, output read_data, output port_a_drive, output port_b_drive,
                    output port_c_drive, output port_drive_enables, output timer_out,
                    input ready);
    modport sink   (input valid, input read_data, input port_a_drive, input port_b_drive,
                    input port_c_drive, input port_drive_enables, input timer_out,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/rio_ram.sv
// ----------------------------------------------------------------------------
// rio_ram
// Scratch RAM with per-entry valid bits, address wrap and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module rio_ram #(
    parameter int RAM_DEPTH = rio_pkg::RIO_RAM_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [rio_pkg::ADDR_W-1:0] i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [rio_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [rio_pkg::DATA_W-1:0] i_wr_data,
    output logic      [rio_pkg::DATA_W-1:0] o_rd_data
);
    import rio_pkg::*;

    localparam int AW = $clog2(RAM_DEPTH);
    localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W+1)'(RAM_DEPTH);

    logic [DATA_W-1:0] r_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;

    // wrap a byte address into the RAM; at most three subtractions for depth >= 64
    function automatic logic [AW-1:0] f_wrap(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] v;
        v = {1'b0, a};
        for (int k = 0; k < 3; k++) begin
            if (v >= DEPTH_W) begin
                v = v - DEPTH_W;
            end
        end
        return v[AW-1:0];
    endfunction

    assign rd_idx = f_wrap(i_rd_addr);
    assign wr_idx = f_wrap(i_wr_addr);

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_idx] <= i_wr_data;
        end
    end

    // mark written entries; reset empties the whole RAM at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    // read port, forwarding a write that lands in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (wr_idx == rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld[rd_idx]) begin
                r_rd_data <= r_mem[rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/rio_regs.sv
// ----------------------------------------------------------------------------
// rio_regs
// Command, status, port latches and timer: applies one event per beat and
// returns the resulting pin view.
// ----------------------------------------------------------------------------
`default_nettype none

module rio_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire rio_pkg::t_item             i_item,
    input  wire logic [rio_pkg::DATA_W-1:0] i_ram_rd,
    output rio_pkg::t_result                o_result
);
    import rio_pkg::*;

    logic [DATA_W-1:0] r_cmd,   n_cmd;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_out_a, n_out_a;
    logic [DATA_W-1:0] r_out_b, n_out_b;
    logic [PC_W-1:0]   r_out_c, n_out_c;
    logic [DATA_W-1:0] r_pin_a, n_pin_a;
    logic [DATA_W-1:0] r_pin_b, n_pin_b;
    logic [DATA_W-1:0] r_pin_c, n_pin_c;
    logic [PORTS-1:0]  r_dir,   n_dir;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [CAM_W-1:0]  r_cam,   n_cam;
    logic r_counting, n_counting;
    logic r_stop,     n_stop;
    logic r_square,   n_square;
    logic r_out_lvl,  n_out_lvl;
    logic r_last_clk, n_last_clk;

    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] m;
    logic              mode3;
    logic              mode4;
    logic              lvl;
    logic [CNT_W-1:0]  full;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  cnt_dec;

    assign d     = i_item.data;
    assign m     = i_item.pin_mask;
    assign mode3 = (r_cmd[3:2] == PC_MODE3);
    assign mode4 = (r_cmd[3:2] == PC_MODE4);
    assign lvl   = d[0] & m[0];

    // reload value: count field, never below two
    assign full    = (r_cam[CNT_W-1:0] > CNT_MIN) ? r_cam[CNT_W-1:0] : CNT_MIN;
    assign half    = full >> 1;
    assign cnt_dec = r_cnt - 1'b1;

    // next state for the event in the stage
    always_comb begin
        n_cmd      = r_cmd;
        n_status   = r_status;
        n_out_a    = r_out_a;
        n_out_b    = r_out_b;
        n_out_c    = r_out_c;
        n_pin_a    = r_pin_a;
        n_pin_b    = r_pin_b;
        n_pin_c    = r_pin_c;
        n_dir      = r_dir;
        n_cnt      = r_cnt;
        n_cam      = r_cam;
        n_counting = r_counting;
        n_stop     = r_stop;
        n_square   = r_square;
        n_out_lvl  = r_out_lvl;
        n_last_clk = r_last_clk;
        rd         = '0;

        case (i_item.mode)
            MODE_IO_WR: begin
                case (i_item.addr[2:0])
                    REG_CMD: begin
                        n_dir = {|d[3:2], d[1], d[0]};
                        n_status[ST_INTE_A] = d[4];
                        n_status[ST_INTE_B] = d[5];
                        case (d[7:6])
                            TCMD_STOP:    n_counting = 1'b0;
                            TCMD_STOP_TC: n_stop = 1'b1;
                            TCMD_START: begin
                                n_stop   = ~r_cam[14];
                                n_square = ~r_cam[15];
                                if (!r_counting) begin
                                    n_cnt      = full;
                                    n_counting = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        n_cmd = d;
                    end
                    REG_PA: n_out_a = d;
                    REG_PB: n_out_b = d;
                    REG_PC: begin
                        // handshake bits stay in mode 3; mode 4 owns the whole latch
                        if (mode3) begin
                            n_out_c = {d[PC_W-1:3], r_out_c[2:0]};
                        end else if (!mode4) begin
                            n_out_c = d[PC_W-1:0];
                        end
                    end
                    REG_TLO: n_cam[7:0]  = d;
                    REG_THI: n_cam[15:8] = d;
                    default: ;
                endcase
            end
            MODE_IO_RD: begin
                case (i_item.addr[2:0])
                    REG_CMD: begin
                        rd = {1'b0, r_status};
                        n_status[ST_TIMER] = 1'b0;
                    end
                    REG_PA: begin
                        if (mode3 || mode4) begin
                            n_status[ST_INTR_A] = 1'b0;
                            n_status[ST_BF_A]   = 1'b0;
                            n_out_c[ST_INTR_A]  = 1'b0;
                            n_out_c[ST_BF_A]    = 1'b0;
                        end
                        rd = r_dir[0] ? r_out_a : r_pin_a;
                    end
                    REG_PB: begin
                        if (mode4) begin
                            n_status[ST_INTR_B] = 1'b0;
                            n_status[ST_BF_B]   = 1'b0;
                            n_out_c[ST_INTR_B]  = 1'b0;
                            n_out_c[ST_BF_B]    = 1'b0;
                        end
                        rd = r_dir[1] ? r_out_b : r_pin_b;
                    end
                    REG_PC:  rd = r_dir[2] ? {2'b00, r_out_c} : r_pin_c;
                    REG_TLO: rd = r_cnt[7:0];
                    REG_THI: rd = {r_cam[15:14], r_cnt[CNT_W-1:8]};
                    default: rd = RD_UNUSED;
                endcase
            end
            MODE_RAM_WR: ;
            MODE_RAM_RD: rd = i_ram_rd;
            MODE_PIN_A: begin
                // strobed input sets buffer full, and interrupt when enabled
                if (mode3 || mode4) begin
                    n_out_c[ST_BF_A]  = 1'b1;
                    n_status[ST_BF_A] = 1'b1;
                    if (r_cmd[4]) begin
                        n_out_c[ST_INTR_A]  = 1'b1;
                        n_status[ST_INTR_A] = 1'b1;
                    end
                end
                n_pin_a = (r_pin_a & ~m) | (d & m);
            end
            MODE_PIN_B: begin
                if (mode4) begin
                    n_out_c[ST_BF_B]  = 1'b1;
                    n_status[ST_BF_B] = 1'b1;
                    if (r_cmd[5]) begin
                        n_out_c[ST_INTR_B]  = 1'b1;
                        n_status[ST_INTR_B] = 1'b1;
                    end
                end
                n_pin_b = (r_pin_b & ~m) | (d & m);
            end
            MODE_PIN_C: n_pin_c = (r_pin_c & ~m) | (d & m);
            MODE_CLOCK: begin
                // count on a falling clock level while running
                if (r_last_clk && !lvl && r_counting) begin
                    if (cnt_dec == '0) begin
                        n_status[ST_TIMER] = 1'b1;
                        if (!r_stop) begin
                            n_cnt     = full;
                            n_out_lvl = 1'b1;
                        end else begin
                            n_cnt      = '0;
                            n_counting = 1'b0;
                            n_out_lvl  = 1'b0;
                        end
                    end else begin
                        n_cnt     = cnt_dec;
                        n_out_lvl = r_square ? (cnt_dec > half) : (cnt_dec > CNT_MIN - 1'b1);
                    end
                end
                n_last_clk = lvl;
            end
            default: ;
        endcase
    end

    // hold state; advance on each beat leaving the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= '0;
            r_status   <= '0;
            r_out_a    <= '0;
            r_out_b    <= '0;
            r_out_c    <= '0;
            r_pin_a    <= '0;
            r_pin_b    <= '0;
            r_pin_c    <= '0;
            r_dir      <= '0;
            r_cnt      <= CNT_RESET;
            r_cam      <= CAM_RESET;
            r_counting <= 1'b0;
            r_stop     <= 1'b0;
            r_square   <= 1'b1;
            r_out_lvl  <= 1'b1;
            r_last_clk <= 1'b0;
        end else if (i_fire) begin
            r_cmd      <= n_cmd;
            r_status   <= n_status;
            r_out_a    <= n_out_a;
            r_out_b    <= n_out_b;
            r_out_c    <= n_out_c;
            r_pin_a    <= n_pin_a;
            r_pin_b    <= n_pin_b;
            r_pin_c    <= n_pin_c;
            r_dir      <= n_dir;
            r_cnt      <= n_cnt;
            r_cam      <= n_cam;
            r_counting <= n_counting;
            r_stop     <= n_stop;
            r_square   <= n_square;
            r_out_lvl  <= n_out_lvl;
            r_last_clk <= n_last_clk;
        end
    end

    // result reflects the state after the event
    always_comb begin
        o_result.read_data          = rd;
        o_result.port_a_drive       = n_out_a;
        o_result.port_b_drive       = n_out_b;
        o_result.port_c_drive       = n_out_c;
        o_result.port_drive_enables = n_dir;
        o_result.timer_out          = n_out_lvl;
    end

endmodule

`default_nettype wire

### rtl/core/ram_io_port_timer_device.sv
// ----------------------------------------------------------------------------
// ram_io_port_timer_device
// Top level: event stage, scratch RAM, register/timer logic and result register.
// ----------------------------------------------------------------------------
// Takes one event beat per clock when the output is not stalled and returns
// one result beat for each, in order. A beat is registered in the event
// stage, where the RAM read data (registered at accept time) and the
// register/timer state are combined; the result is registered at the output.
// The throughput is one beat per cycle while the output accepts, set by the
// state update in the event stage; a RAM write in the stage is forwarded to
// a read accepted in the same cycle. Reset returns the register/timer state to
// its reset values and clears the stage, result and RAM valid flags, so the
// block is ready for events as soon as reset is released.
`default_nettype none
`include "assert_macros.svh"

module ram_io_port_timer_device #(
    parameter int RAM_DEPTH = rio_pkg::RIO_RAM_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rio_in_if.sink     i_item,
    rio_out_if.source  o_result
);
    import rio_pkg::*;

    logic    r_s1_vld;
    t_item   r_s1;
    logic    r_out_vld;
    t_result r_res;
    logic    accept;
    logic    s1_fire;
    logic    s1_nonread;
    logic    ram_we;
    logic [DATA_W-1:0] ram_rd;
    t_result res;

    // the stage moves on when the result register is free or being emptied
    assign s1_fire      = r_s1_vld && (!r_out_vld || o_result.ready);
    assign i_item.ready = i_rst_n && (!r_s1_vld || s1_fire);
    assign accept       = i_item.valid && i_item.ready;
    assign ram_we       = s1_fire && (r_s1.mode == MODE_RAM_WR);
    assign s1_nonread   = s1_fire && (r_s1.mode != MODE_IO_RD) && (r_s1.mode != MODE_RAM_RD);

    // event stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.mode     <= t_mode'(i_item.mode);
            r_s1.addr     <= i_item.addr;
            r_s1.data     <= i_item.data;
            r_s1.pin_mask <= i_item.pin_mask;
        end
    end

    rio_ram #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_item.addr),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_s1.addr),
        .i_wr_data (r_s1.data),
        .o_rd_data (ram_rd)
    );

    rio_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1),
        .i_ram_rd (ram_rd),
        .o_result (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_res <= res;
        end
    end

    assign o_result.valid              = r_out_vld;
    assign o_result.read_data          = r_res.read_data;
    assign o_result.port_a_drive       = r_res.port_a_drive;
    assign o_result.port_b_drive       = r_res.port_b_drive;
    assign o_result.port_c_drive       = r_res.port_c_drive;
    assign o_result.port_drive_enables = r_res.port_drive_enables;
    assign o_result.timer_out          = r_res.timer_out;

    // an accepted beat always lands in the stage
    `ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, accept, r_s1_vld)
    // a beat leaving the stage always shows up as a result
    `ASSERT_NEXT(a_fire_shows, i_clk, i_rst_n, s1_fire, r_out_vld)
    // backpressure only when both registers hold beats
    `ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !i_item.ready, r_s1_vld && r_out_vld)
    // events other than reads return zero data
    `ASSERT_NEXT(a_nonread_zero, i_clk, i_rst_n, s1_nonread, o_result.read_data == 8'd0)

endmodule

`default_nettype wire

### sim/ram_io_port_timer_device_tb.sv
// ----------------------------------------------------------------------------
// ram_io_port_timer_device_tb
// Self-checking bench for the RAM, I/O port and timer device. A queue of
// events (directed corner cases, then random sequences for the timer,
// strobed port handshakes, RAM traffic and noise) feeds a clocked driver;
// a clocked monitor compares every result beat field by field against a
// predicted copy of the chip state. Both sides idle and stall in phases.
// ----------------------------------------------------------------------------
`default_nettype none

module ram_io_port_timer_device_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rio_pkg::*;

    localparam int RANDOM_EVENTS = 1200;
    localparam int DRAIN_AT      = 560;
    localparam int RX_HOLD_AT    = 150;
    localparam int RX_HOLD_LEN   = 300;

    logic i_clk;
    logic i_rst_n;

    rio_in_if  item_if ();
    rio_out_if result_if ();

    ram_io_port_timer_device u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // predicted chip state
    logic [7:0]  mem_img [0:RIO_RAM_DEPTH-1];
    logic [7:0]  cmd_r;
    logic [6:0]  stat_r;
    logic [7:0]  out_latch [3];
    logic [7:0]  pin_latch [3];
    logic [7:0]  rd_mask [3];
    int          down_cnt;
    logic [15:0] cam_r;
    logic        running;
    logic        one_shot;
    logic        square;
    logic        tmr_out;
    logic        clk_lvl;

    t_item   pending_events [$];
    t_result chip_replies [$];
    t_item   cur_event;
    int      sent_cnt;
    int      total_events;
    int      mismatches = 0;
    int      rx_hold_left;
    logic    rx_hold_done;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int reload_value();
        int v;
        v = int'(cam_r[13:0]);
        return (v > 2) ? v : 2;
    endfunction

    function automatic logic pulse_level(input int full);
        return square ? (down_cnt > (full >>> 1)) : (down_cnt > 1);
    endfunction

    function automatic logic [7:0] port_level(input int p);
        return (pin_latch[p] & rd_mask[p]) | (out_latch[p] & ~rd_mask[p]);
    endfunction

    function automatic void strobe(input int bf, input int intr, input logic en);
        out_latch[2][bf] = 1'b1;
        stat_r[bf]       = 1'b1;
        if (en) begin
            out_latch[2][intr] = 1'b1;
            stat_r[intr]       = 1'b1;
        end
    endfunction

    // Apply one event to the predicted state and return the result it causes.
    function automatic t_result chip_event(input t_item ev);
        t_result    r;
        logic [7:0] rd;
        logic [7:0] d;
        logic [2:0] rg;
        logic       lvl;
        logic       hs3;
        logic       hs4;
        int         full;
        rd  = '0;
        d   = ev.data;
        rg  = ev.addr[2:0];
        hs3 = (cmd_r[3:2] == PC_MODE3);
        hs4 = (cmd_r[3:2] == PC_MODE4);
        case (ev.mode)
            MODE_IO_WR: begin
                case (rg)
                    REG_CMD: begin
                        rd_mask[0]        = d[0] ? 8'h00 : 8'hff;
                        rd_mask[1]        = d[1] ? 8'h00 : 8'hff;
                        rd_mask[2]        = (d[3:2] != 2'b00) ? 8'h00 : 8'hff;
                        stat_r[ST_INTE_A] = d[4];
                        stat_r[ST_INTE_B] = d[5];
                        case (d[7:6])
                            TCMD_STOP:    running = 1'b0;
                            TCMD_STOP_TC: one_shot = 1'b1;
                            TCMD_START: begin
                                // a running counter keeps its count, only the mode changes
                                one_shot = !cam_r[14];
                                square   = !cam_r[15];
                                if (!running) begin
                                    down_cnt = reload_value();
                                    running  = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        cmd_r = d;
                    end
                    REG_PA: out_latch[0] = d;
                    REG_PB: out_latch[1] = d;
                    REG_PC: begin
                        // handshake bits survive in mode 3; mode 4 ignores the write
                        if (hs3) d[2:0] = out_latch[2][2:0];
                        if (!hs4) out_latch[2] = {2'b00, d[5:0]};
                    end
                    REG_TLO: cam_r[7:0]  = d;
                    REG_THI: cam_r[15:8] = d;
                    default: ;
                endcase
            end
            MODE_IO_RD: begin
                case (rg)
                    REG_CMD: begin
                        rd               = {1'b0, stat_r};
                        stat_r[ST_TIMER] = 1'b0;
                    end
                    REG_PA: begin
                        if (hs3 || hs4) begin
                            stat_r[ST_INTR_A]       = 1'b0;
                            stat_r[ST_BF_A]         = 1'b0;
                            out_latch[2][ST_INTR_A] = 1'b0;
                            out_latch[2][ST_BF_A]   = 1'b0;
                        end
                        rd = port_level(0);
                    end
                    REG_PB: begin
                        if (hs4) begin
                            stat_r[ST_INTR_B]       = 1'b0;
                            stat_r[ST_BF_B]         = 1'b0;
                            out_latch[2][ST_INTR_B] = 1'b0;
                            out_latch[2][ST_BF_B]   = 1'b0;
                        end
                        rd = port_level(1);
                    end
                    REG_PC:  rd = port_level(2);
                    REG_TLO: rd = down_cnt[7:0];
                    REG_THI: rd = {cam_r[15:14], down_cnt[13:8]};
                    default: rd = RD_UNUSED;
                endcase
            end
            MODE_RAM_WR: mem_img[ev.addr % RIO_RAM_DEPTH] = d;
            MODE_RAM_RD: rd = mem_img[ev.addr % RIO_RAM_DEPTH];
            MODE_PIN_A: begin
                if (hs3 || hs4) strobe(ST_BF_A, ST_INTR_A, cmd_r[4]);
                pin_latch[0] = (pin_latch[0] & ~ev.pin_mask) | (d & ev.pin_mask);
            end
            MODE_PIN_B: begin
                if (hs4) strobe(ST_BF_B, ST_INTR_B, cmd_r[5]);
                pin_latch[1] = (pin_latch[1] & ~ev.pin_mask) | (d & ev.pin_mask);
            end
            MODE_PIN_C: pin_latch[2] = (pin_latch[2] & ~ev.pin_mask) | (d & ev.pin_mask);
            default: begin
                // count on a falling timer clock level
                lvl = d[0] & ev.pin_mask[0];
                if (clk_lvl && !lvl && running) begin
                    down_cnt = down_cnt - 1;
                    full     = reload_value();
                    tmr_out  = pulse_level(full);
                    if (down_cnt <= 0) begin
                        stat_r[ST_TIMER] = 1'b1;
                        if (!one_shot) begin
                            down_cnt = down_cnt + full;
                            tmr_out  = pulse_level(full);
                        end else begin
                            running = 1'b0;
                        end
                    end
                end
                clk_lvl = lvl;
            end
        endcase
        r.read_data          = rd;
        r.port_a_drive       = out_latch[0];
        r.port_b_drive       = out_latch[1];
        r.port_c_drive       = out_latch[2][5:0];
        r.port_drive_enables = {rd_mask[2] == 8'h00, rd_mask[1] == 8'h00, rd_mask[0] == 8'h00};
        r.timer_out          = tmr_out;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_ev(input t_mode m, input logic [7:0] a, input logic [7:0] d,
                           input logic [7:0] k);
        t_item it;
        it.mode     = m;
        it.addr     = a;
        it.data     = d;
        it.pin_mask = k;
        pending_events.push_back(it);
    endtask

    // register number with random upper address bits
    function automatic logic [7:0] reg_addr(input logic [2:0] rg);
        logic [4:0] hi;
        hi = 5'($urandom_range(0, 31));
        return {hi, rg};
    endfunction

    function automatic logic [7:0] rbyte();
        return 8'($urandom_range(0, 255));
    endfunction

    // idle percentage per phase, by number of accepted beats
    function automatic int gap_pct(input int n, input logic rx);
        if (n < 300) return 0;
        else if (n < 550) return rx ? 0 : 74;
        else if (n < 800) return rx ? 74 : 0;
        else if (n < 1050) return 29;
        else return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int         kind;
        int         n;
        int         i;
        int         directed_n;
        logic       lvl_gen;
        logic [7:0] ra;
        logic [7:0] rcmd;
        logic [7:0] kmask;

        i_rst_n = 1'b0;

        // reset image of the chip
        for (i = 0; i < RIO_RAM_DEPTH; i++) mem_img[i] = 8'h00;
        for (i = 0; i < PORTS; i++) begin
            out_latch[i] = 8'h00;
            pin_latch[i] = 8'h00;
            rd_mask[i]   = 8'hff;
        end
        cmd_r    = 8'h00;
        stat_r   = 7'h00;
        down_cnt = int'(CNT_RESET);
        cam_r    = CAM_RESET;
        running  = 1'b0;
        one_shot = 1'b0;
        square   = 1'b1;
        tmr_out  = 1'b1;
        clk_lvl  = 1'b0;

        // RAM extremes
        push_ev(MODE_RAM_WR, 8'h00, 8'hff, 8'h00);
        push_ev(MODE_RAM_WR, 8'hff, 8'h00, 8'hff);
        push_ev(MODE_RAM_RD, 8'h00, 8'h00, 8'h00);
        push_ev(MODE_RAM_RD, 8'hff, 8'hff, 8'hff);
        // unused registers
        push_ev(MODE_IO_WR, 8'h06, 8'hff, 8'hff);
        push_ev(MODE_IO_RD, 8'h06, 8'h00, 8'h00);
        push_ev(MODE_IO_RD, 8'hff, 8'h00, 8'h00);
        // count of one loads as two, one-shot square wave, run to terminal count
        push_ev(MODE_IO_WR, {5'd0, REG_TLO}, 8'h01, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_THI}, 8'h00, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_CMD}, {TCMD_START, 6'd0}, 8'h00);
        push_ev(MODE_CLOCK, 8'h00, 8'h01, 8'hff);
        push_ev(MODE_CLOCK, 8'h00, 8'h00, 8'hff);
        push_ev(MODE_CLOCK, 8'h00, 8'h01, 8'hff);
        push_ev(MODE_CLOCK, 8'h00, 8'h00, 8'hff);
        // status read returns the timer flag, then clears it
        push_ev(MODE_IO_RD, {5'd0, REG_CMD}, 8'h00, 8'h00);
        push_ev(MODE_IO_RD, {5'd0, REG_CMD}, 8'h00, 8'h00);
        // count of zero with reload, then restart while running
        push_ev(MODE_IO_WR, {5'd0, REG_TLO}, 8'h00, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_THI}, 8'h40, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_CMD}, {TCMD_START, 6'd0}, 8'h00);
        push_ev(MODE_CLOCK, 8'h00, 8'h01, 8'h01);
        push_ev(MODE_CLOCK, 8'h00, 8'h00, 8'h01);
        push_ev(MODE_IO_WR, {5'd0, REG_THI}, 8'hc0, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_CMD}, {TCMD_START, 6'd0}, 8'h00);
        push_ev(MODE_IO_RD, {5'd0, REG_THI}, 8'h00, 8'h00);
        // port C write under handshake modes 3 and 4
        push_ev(MODE_IO_WR, {5'd0, REG_CMD}, 8'h14, 8'h00);
        push_ev(MODE_PIN_A, 8'h00, 8'haa, 8'hf0);
        push_ev(MODE_IO_WR, {5'd0, REG_PC}, 8'hff, 8'h00);
        push_ev(MODE_IO_RD, {5'd0, REG_PA}, 8'h00, 8'h00);
        push_ev(MODE_IO_WR, {5'd0, REG_CMD}, 8'h28, 8'h00);
        push_ev(MODE_PIN_B, 8'h00, 8'h55, 8'h0f);
        push_ev(MODE_IO_WR, {5'd0, REG_PC}, 8'h00, 8'h00);
        push_ev(MODE_IO_RD, {5'd0, REG_PB}, 8'h00, 8'h00);

        directed_n = pending_events.size();
        lvl_gen    = 1'b0;
        while (pending_events.size() - directed_n < RANDOM_EVENTS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                // timer: load a short count, start, then clock it
                ra = ($urandom_range(0, 7) == 0) ? rbyte() : 8'($urandom_range(0, 12));
                push_ev(MODE_IO_WR, reg_addr(REG_TLO), ra, rbyte());
                ra = ($urandom_range(0, 9) == 0) ? rbyte() : {2'($urandom_range(0, 3)), 6'd0};
                push_ev(MODE_IO_WR, reg_addr(REG_THI), ra, rbyte());
                rcmd = {TCMD_START, 6'($urandom_range(0, 63))};
                if ($urandom_range(0, 7) == 0) rcmd[7:6] = 2'($urandom_range(0, 3));
                push_ev(MODE_IO_WR, reg_addr(REG_CMD), rcmd, rbyte());
                n = $urandom_range(2, 30);
                for (i = 0; i < n; i++) begin
                    lvl_gen = ~lvl_gen;
                    kmask   = {7'($urandom_range(0, 127)), ($urandom_range(0, 9) != 0)};
                    push_ev(MODE_CLOCK, rbyte(), {7'($urandom_range(0, 127)), lvl_gen}, kmask);
                    case ($urandom_range(0, 19))
                        0, 1: push_ev(MODE_IO_RD, reg_addr(REG_CMD), rbyte(), rbyte());
                        2:    push_ev(MODE_IO_RD, reg_addr(REG_TLO), rbyte(), rbyte());
                        3:    push_ev(MODE_IO_RD, reg_addr(REG_THI), rbyte(), rbyte());
                        4:    push_ev(MODE_IO_WR, reg_addr(REG_CMD),
                                      {2'($urandom_range(1, 3)), 6'($urandom_range(0, 63))},
                                      rbyte());
                        default: ;
                    endcase
                end
            end else if (kind <= 4) begin
                // strobed handshake on ports A and B
                rcmd = rbyte();
                rcmd[3:2] = $urandom_range(0, 1) ? PC_MODE3 : PC_MODE4;
                if ($urandom_range(0, 3) != 0) rcmd[7:6] = TCMD_NOP;
                push_ev(MODE_IO_WR, reg_addr(REG_CMD), rcmd, rbyte());
                n = $urandom_range(3, 12);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 8))
                        0, 1: push_ev(MODE_PIN_A, rbyte(), rbyte(), rbyte());
                        2, 3: push_ev(MODE_PIN_B, rbyte(), rbyte(), rbyte());
                        4:    push_ev(MODE_IO_RD, reg_addr(REG_PA), rbyte(), rbyte());
                        5:    push_ev(MODE_IO_RD, reg_addr(REG_PB), rbyte(), rbyte());
                        6:    push_ev(MODE_IO_RD, reg_addr(REG_CMD), rbyte(), rbyte());
                        7:    push_ev(MODE_IO_WR, reg_addr(REG_PC), rbyte(), rbyte());
                        default: push_ev(MODE_IO_RD, reg_addr(REG_PC), rbyte(), rbyte());
                    endcase
                end
            end else if (kind <= 6) begin
                // RAM: write a few bytes, read them back
                ra = rbyte();
                n  = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    push_ev(MODE_RAM_WR, 8'(ra + i), rbyte(), rbyte());
                for (i = 0; i < n; i++)
                    push_ev(MODE_RAM_RD, 8'(ra + i), rbyte(), rbyte());
                push_ev(MODE_RAM_RD, rbyte(), rbyte(), rbyte());
            end else begin
                // noise: any event with any fields
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    push_ev(t_mode'($urandom_range(0, 7)), rbyte(), rbyte(), rbyte());
            end
        end
        total_events = pending_events.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every event to be taken and every result to come back
        while (sent_cnt < total_events || chip_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && chip_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: predict each accepted beat, then offer the next event
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int   n_acc;
        logic fire;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            sent_cnt      <= 0;
        end else begin
            n_acc = sent_cnt;
            if (item_if.valid && item_if.ready) begin
                chip_replies.push_back(chip_event(cur_event));
                n_acc = n_acc + 1;
            end
            sent_cnt <= n_acc;
            // hold an offered beat until it is taken
            if (!(item_if.valid && !item_if.ready)) begin
                fire = (pending_events.size() != 0)
                    && !(n_acc == DRAIN_AT && chip_replies.size() != 0)
                    && ($urandom_range(0, 99) >= gap_pct(n_acc, 1'b0));
                if (fire) begin
                    cur_event         = pending_events.pop_front();
                    item_if.mode     <= cur_event.mode;
                    item_if.addr     <= cur_event.addr;
                    item_if.data     <= cur_event.data;
                    item_if.pin_mask <= cur_event.pin_mask;
                end
                item_if.valid <= fire;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off, so the block backs up into its input
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (!rx_hold_done && sent_cnt >= RX_HOLD_AT) begin
            rx_hold_left <= RX_HOLD_LEN;
            rx_hold_done <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string fld, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at %0t: expected %02h, got %02h",
                         fld, $realtime, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (chip_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with nothing predicted at %0t", $realtime);
                end else begin
                    want = chip_replies.pop_front();
                    check_field("read_data", want.read_data, result_if.read_data);
                    check_field("port_a_drive", want.port_a_drive, result_if.port_a_drive);
                    check_field("port_b_drive", want.port_b_drive, result_if.port_b_drive);
                    check_field("port_c_drive", 8'(want.port_c_drive),
                                8'(result_if.port_c_drive));
                    check_field("port_drive_enables", 8'(want.port_drive_enables),
                                8'(result_if.port_drive_enables));
                    check_field("timer_out", 8'(want.timer_out), 8'(result_if.timer_out));
                end
            end
            result_if.ready <= (rx_hold_left == 0)
                && ($urandom_range(0, 99) >= gap_pct(sent_cnt, 1'b1));
        end
    end

endmodule

`default_nettype wire
